### rtl/trer_pkg.sv
// shared types, constants and fixed-point helpers for the odd-even reduction core
`default_nettype none

package trer_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;
  localparam logic signed [63:0] ROUND_HALF = 64'sd32768;
  localparam int QFRAC = 16;

  // config register index, word address bit 2
  typedef enum logic {
    REG_FIRST_BOUNDARY = 1'b0,
    REG_LAST_BOUNDARY  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] sub_coef;
    logic signed [31:0] diag_coef;
    logic signed [31:0] super_coef;
    logic signed [31:0] rhs_value;
    logic               final_row;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] red_lower;
    logic signed [31:0] red_main;
    logic signed [31:0] red_upper;
    logic signed [31:0] red_rhs;
    logic               red_last;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] rhs;
  } row_t;

  // one closed window, queued for the arithmetic back end
  typedef struct packed {
    row_t even_row;
    row_t odd_row;
    row_t close_row;
    logic first;
    logic last;
  } job_t;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(SAT_MAX)) begin
      r = SAT_MAX;
    end else if (v < 64'(SAT_MIN)) begin
      r = SAT_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // q16.16 product, round half up, floor shift, saturate
  function automatic logic signed [31:0] qmul(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    logic signed [63:0] p;
    logic signed [63:0] s;
    p = $signed({{32{x[31]}}, x}) * $signed({{32{y[31]}}, y});
    s = (p + ROUND_HALF) >>> QFRAC;
    return sat64(s);
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
    logic signed [31:0] r;
    if (s[32] != s[31]) begin
      r = s[32] ? SAT_MIN : SAT_MAX;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    logic signed [32:0] s;
    s = $signed({x[31], x}) + $signed({y[31], y});
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
    logic signed [32:0] s;
    s = $signed({x[31], x}) - $signed({y[31], y});
    return sat33(s);
  endfunction

endpackage

`default_nettype wire

### rtl/tridiagonal_odd_even_reduction_core.sv
// top level of the tridiagonal odd-even reduction core
`default_nettype none

// One level of cyclic reduction on a streamed tridiagonal system. Rows
// (lower, main, upper, right side, all signed Q16.16) enter one transaction per
// row; rows 2k, 2k+1 and 2k+2 form a window and each closing row yields one
// reduced row over the even unknowns, with the first reduced right side
// corrected by first_boundary and the one closed by a final row corrected by
// last_boundary. A final row on an unfinished window drops the partial system.
// Rows that do not close a window are accepted without waiting for queue
// space. Each closing row queues a job (two-entry queue) for the back end,
// which runs every product and sum through a single shared 32x32 multiplier
// and saturating adder: a job occupies the back end from take through 20
// arithmetic steps to the hand-off to the output register, and no new job is
// taken before that. The output register lets the back end start the next
// job while a result waits. Config registers sit at byte offset 0
// (first_boundary) and 4 (last_boundary) and should only be written
// while the core is idle.

module tridiagonal_odd_even_reduction_core
  import trer_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // apb-style config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // row input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  // reduced row output
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data
);

  logic signed [31:0] first_boundary;
  logic signed [31:0] last_boundary;
  reg_idx_t           reg_sel;
  logic               cfg_write;

  // front/queue/back handshake
  logic push;
  job_t push_job;
  logic q_full;
  logic pop;
  job_t head_job;
  logic head_valid;

  // register decode: byte lanes below the word offset are ignored
  assign reg_sel   = reg_idx_t'(paddr[2]);
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_boundary <= '0;
      last_boundary  <= '0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_FIRST_BOUNDARY: first_boundary <= pwdata;
        REG_LAST_BOUNDARY:  last_boundary  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FIRST_BOUNDARY: prdata = first_boundary;
      REG_LAST_BOUNDARY:  prdata = last_boundary;
      default:            prdata = '0;
    endcase
  end

  // front end: window tracking, only closing rows need queue space
  trer_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // decouples row intake from the long arithmetic sequence
  trer_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_job   (head_job),
    .head_valid (head_valid)
  );

  // back end: sequenced arithmetic and output register
  trer_back u_back (
    .clk            (clk),
    .rst            (rst),
    .first_boundary (first_boundary),
    .last_boundary  (last_boundary),
    .q_valid        (head_valid),
    .q_job          (head_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule

`default_nettype wire

### rtl/trer_front.sv
// front end: row window tracking and job formation
`default_nettype none

module trer_front
  import trer_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire logic     q_full,
  output logic          push,
  output job_t          push_job
);

  typedef enum logic [2:0] {
    PH_EVEN  = 3'b001,
    PH_ODD   = 3'b010,
    PH_CLOSE = 3'b100
  } phase_t;

  phase_t phase;
  phase_t phase_next;
  logic   first_pending;
  logic   first_pending_next;
  row_t   even_store;
  row_t   odd_store;
  row_t   row;
  logic   in_fire;

  assign row = '{coef_a: in_data.sub_coef, coef_b: in_data.diag_coef,
                 coef_c: in_data.super_coef, rhs: in_data.rhs_value};

  // only a closing row needs queue space
  assign in_ready = (phase != PH_CLOSE) || !q_full;
  assign in_fire  = in_valid && in_ready;
  assign push     = in_fire && (phase == PH_CLOSE);

  assign push_job = '{even_row: even_store, odd_row: odd_store, close_row: row,
                      first: first_pending, last: in_data.final_row};

  always_comb begin
    phase_next         = phase;
    first_pending_next = first_pending;
    if (in_fire) begin
      unique case (phase)
        PH_ODD: begin
          phase_next = in_data.final_row ? PH_EVEN : PH_CLOSE;
          if (in_data.final_row) first_pending_next = 1'b1;
        end
        PH_CLOSE: begin
          phase_next         = in_data.final_row ? PH_EVEN : PH_ODD;
          first_pending_next = in_data.final_row;
        end
        default: begin
          phase_next = in_data.final_row ? PH_EVEN : PH_ODD;
          if (in_data.final_row) first_pending_next = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_EVEN;
      first_pending <= 1'b1;
    end else begin
      phase         <= phase_next;
      first_pending <= first_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (phase == PH_ODD) begin
        odd_store <= row;
      end else if (phase != PH_CLOSE || !in_data.final_row) begin
        even_store <= row;
      end
    end
  end

  // a system that ends in a closed window leaves the tracker fresh
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    push && in_data.final_row |=> phase == PH_EVEN && first_pending)
    else $error("tracker not reset after last window");

  a_second_window: assert property (@(posedge clk) disable iff (rst)
    push && !in_data.final_row |=> !first_pending && phase == PH_ODD)
    else $error("first window mark not cleared");

endmodule

`default_nettype wire

### rtl/trer_queue.sv
// short job queue between front and back end
`default_nettype none

module trer_queue
  import trer_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output job_t      head_job,
  output logic      head_valid
);

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + QPTR_W'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

### rtl/trer_back.sv
// back end: sequenced reduction arithmetic on one shared multiplier, output register
`default_nettype none

module trer_back
  import trer_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic signed [31:0] first_boundary,
  input  wire logic signed [31:0] last_boundary,
  input  wire logic               q_valid,
  input  wire job_t               q_job,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_item_t               out_data
);

  typedef enum logic [21:0] {
    ST_IDLE = 22'h00_0001,
    ST_B0C1 = 22'h00_0002,
    ST_T1   = 22'h00_0004,
    ST_LO   = 22'h00_0008,
    ST_P1   = 22'h00_0010,
    ST_P2   = 22'h00_0020,
    ST_D1   = 22'h00_0040,
    ST_M1   = 22'h00_0080,
    ST_M2   = 22'h00_0100,
    ST_MN   = 22'h00_0200,
    ST_UP   = 22'h00_0400,
    ST_Q1   = 22'h00_0800,
    ST_Q2   = 22'h00_1000,
    ST_D2   = 22'h00_2000,
    ST_S1   = 22'h00_4000,
    ST_S2   = 22'h00_8000,
    ST_RS   = 22'h01_0000,
    ST_F    = 22'h02_0000,
    ST_FS   = 22'h04_0000,
    ST_L    = 22'h08_0000,
    ST_LS   = 22'h10_0000,
    ST_EMIT = 22'h20_0000
  } step_t;

  step_t state;
  job_t  job;

  logic signed [31:0] k_reg;
  logic signed [31:0] t_reg;
  logic signed [31:0] u_reg;
  logic signed [31:0] lo_reg;
  logic signed [31:0] mn_reg;
  logic signed [31:0] up_reg;
  logic signed [31:0] rs_reg;

  logic signed [31:0] mx;
  logic signed [31:0] my;
  logic signed [31:0] ax;
  logic signed [31:0] ay;
  logic               sub_op;
  logic signed [31:0] mul_res;
  logic signed [31:0] as_res;
  logic               emit_go;

  assign pop     = (state == ST_IDLE) && q_valid;
  assign emit_go = (state == ST_EMIT) && (!out_valid || out_ready);

  // operand selection for the shared multiplier and adder
  always_comb begin
    mx     = '0;
    my     = '0;
    ax     = t_reg;
    ay     = u_reg;
    sub_op = 1'b0;
    unique case (state)
      ST_B0C1: begin mx = job.even_row.coef_b; my = job.odd_row.coef_c; end
      ST_T1:   begin mx = job.close_row.coef_b; my = job.odd_row.coef_a; end
      ST_LO:   begin mx = t_reg; my = job.even_row.coef_a; end
      ST_P1:   begin mx = job.odd_row.coef_a; my = job.even_row.coef_c; end
      ST_P2:   begin mx = job.even_row.coef_b; my = job.odd_row.coef_b; end
      ST_D1:   sub_op = 1'b1;
      ST_M1:   begin mx = job.close_row.coef_b; my = t_reg; end
      ST_M2:   begin mx = k_reg; my = job.close_row.coef_a; end
      ST_UP:   begin mx = k_reg; my = job.close_row.coef_c; end
      ST_Q1:   begin mx = job.odd_row.coef_a; my = job.even_row.rhs; end
      ST_Q2:   begin mx = job.even_row.coef_b; my = job.odd_row.rhs; end
      ST_D2:   sub_op = 1'b1;
      ST_S1:   begin mx = job.close_row.coef_b; my = t_reg; end
      ST_S2:   begin mx = k_reg; my = job.close_row.rhs; end
      ST_F:    begin mx = lo_reg; my = first_boundary; end
      ST_FS:   begin ax = rs_reg; sub_op = 1'b1; end
      ST_L:    begin mx = up_reg; my = last_boundary; end
      ST_LS:   begin ax = rs_reg; sub_op = 1'b1; end
      default: ;
    endcase
  end

  assign mul_res = qmul(mx, my);
  assign as_res  = sub_op ? qsub(ax, ay) : qadd(ax, ay);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a new result takes the register even as the old one leaves
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (q_valid) state <= ST_B0C1;
        ST_B0C1: state <= ST_T1;
        ST_T1:   state <= ST_LO;
        ST_LO:   state <= ST_P1;
        ST_P1:   state <= ST_P2;
        ST_P2:   state <= ST_D1;
        ST_D1:   state <= ST_M1;
        ST_M1:   state <= ST_M2;
        ST_M2:   state <= ST_MN;
        ST_MN:   state <= ST_UP;
        ST_UP:   state <= ST_Q1;
        ST_Q1:   state <= ST_Q2;
        ST_Q2:   state <= ST_D2;
        ST_D2:   state <= ST_S1;
        ST_S1:   state <= ST_S2;
        ST_S2:   state <= ST_RS;
        ST_RS:   state <= ST_F;
        ST_F:    state <= ST_FS;
        ST_FS:   state <= ST_L;
        ST_L:    state <= ST_LS;
        ST_LS:   state <= ST_EMIT;
        ST_EMIT: if (emit_go) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, written by step
  always_ff @(posedge clk) begin
    if (pop) job <= q_job;
    unique case (state)
      ST_B0C1: k_reg <= mul_res;
      ST_T1:   t_reg <= mul_res;
      ST_LO:   lo_reg <= mul_res;
      ST_P1:   t_reg <= mul_res;
      ST_P2:   u_reg <= mul_res;
      ST_D1:   t_reg <= as_res;
      ST_M1:   t_reg <= mul_res;
      ST_M2:   u_reg <= mul_res;
      ST_MN:   mn_reg <= as_res;
      ST_UP:   up_reg <= mul_res;
      ST_Q1:   t_reg <= mul_res;
      ST_Q2:   u_reg <= mul_res;
      ST_D2:   t_reg <= as_res;
      ST_S1:   t_reg <= mul_res;
      ST_S2:   u_reg <= mul_res;
      ST_RS:   rs_reg <= as_res;
      ST_F:    u_reg <= mul_res;
      ST_FS:   if (job.first) rs_reg <= as_res;
      ST_L:    u_reg <= mul_res;
      ST_LS:   if (job.last) rs_reg <= as_res;
      default: ;
    endcase
    if (emit_go) begin
      out_data <= '{red_lower: lo_reg, red_main: mn_reg, red_upper: up_reg,
                    red_rhs: rs_reg, red_last: job.last};
    end
  end

  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == ST_B0C1)
    else $error("job taken while sequencer busy");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> out_valid && state == ST_IDLE)
    else $error("result not loaded into output register");

endmodule

`default_nettype wire
